/* hw/rtl/swe_pkg.sv */
package swe_pkg;

	// Default number of exponential stages and the size of the logarithm table.
	localparam int CORDIC_STAGES_DEF = 20;
	localparam int ROM_SIZE = 33;

	// The quotient a = w / (1 + w) has 31 fraction bits, one per divider stage.
	localparam int DIV_STEPS = 31;

	// Byte address width of the register port: eight 32-bit registers.
	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_WAVE_HEIGHT  = 3'd0,
		REG_WAVE_NUMBER  = 3'd1,
		REG_CELERITY     = 3'd2,
		REG_DIR_X        = 3'd3,
		REG_DIR_Y        = 3'd4,
		REG_DIR_Z        = 3'd5,
		REG_PHASE_OFFSET = 3'd6,
		REG_SEA_LEVEL    = 3'd7
	} reg_idx_t;

	// One beat inside the exponential pipeline.
	typedef struct packed {
		logic [31:0] s;
		logic [33:0] p;
		logic [6:0]  sh;
	} exp_beat_t;

	// One beat inside the divider pipeline.
	typedef struct packed {
		logic [33:0] r;
		logic [33:0] d;
		logic [30:0] q;
	} div_beat_t;

	typedef logic [31:0] ln_rom_t [ROM_SIZE];

	// Restoring division, used only while building constants.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// ln(1 + 2^-idx) in Q.32, rounded to nearest; idx zero gives ln 2.
	function automatic logic [31:0] ln_q32(input int idx);
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] rnd;
		acc = '0;
		if (idx == 0) begin
			for (int n = 1; n <= 62; n++) begin
				acc = acc + udiv64(64'd1 << (62 - n), 64'(n));
			end
		end else begin
			for (int n = 1; n * idx <= 62; n++) begin
				t = udiv64(64'd1 << (62 - n * idx), 64'(n));
				if (n % 2 == 1) begin
					acc = acc + t;
				end else begin
					acc = acc - t;
				end
			end
		end
		rnd = (acc + (64'd1 << 29)) >> 30;
		return rnd[31:0];
	endfunction

	function automatic ln_rom_t ln_rom_build();
		ln_rom_t rom;
		for (int i = 0; i < ROM_SIZE; i++) begin
			rom[i] = ln_q32(i);
		end
		return rom;
	endfunction

	localparam ln_rom_t LN_ROM = ln_rom_build();
	localparam logic [31:0] LN2_Q32 = ln_q32(0);

	// floor(2^20 / ln2), that is 2^52 / LN2_Q32, for the reciprocal estimate of y / ln2.
	localparam logic [20:0] RECIP_LN2 = 21'((64'd1 << 52) / {32'd0, LN2_Q32});

endpackage

/* hw/rtl/solitary_wave_elevation_unit.sv */
// Solitary wave elevation unit: returns the free-surface elevation of a first-order
// solitary wave, H * sech^2(k * |c*t - p.d + offset|) + sea_level, in Q16.16 metres.
// Query beats (pos_x, pos_y, pos_z, sim_time) enter on query_valid/query_stall and one
// result beat (elevation) leaves on result_valid/result_stall for every query, in order.
// The wave parameters sit in eight 32-bit registers on the APB-style port, register i at
// byte address 4*i; they should only be written while no query is in flight.
// The datapath is a single pipeline that takes one query beat every cycle while query_stall
// is low. A query passes through nine front stages for the phase and the range reduction,
// one stage per exponential step, one shift stage, 31 divider stages, three multiply stages
// and the output register.
// The output register is backed by a one-beat skid buffer. When the receiver stalls, the
// next finished beat parks in the skid buffer and query_stall rises with it, freezing the
// whole pipeline until the receiver takes a beat again; nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline and loads the register reset values, the
// propagation direction being +x.
module solitary_wave_elevation_unit #(
	parameter int CORDIC_STAGES = swe_pkg::CORDIC_STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swe_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,

	input  logic                        query_valid,
	output logic                        query_stall,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic signed [31:0]          pos_z,
	input  logic [31:0]                 sim_time,

	output logic                        result_valid,
	input  logic                        result_stall,
	output logic signed [31:0]          elevation
);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [23:0]        wave_height_q;
	logic [23:0]        wave_number_q;
	logic [23:0]        celerity_q;
	logic signed [15:0] dir_x_q;
	logic signed [15:0] dir_y_q;
	logic signed [15:0] dir_z_q;
	logic signed [31:0] phase_offset_q;
	logic signed [31:0] sea_level_q;

	logic              cfg_wr;
	swe_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = swe_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_height_q  <= '0;
			wave_number_q  <= '0;
			celerity_q     <= '0;
			dir_x_q        <= 16'sd16384;
			dir_y_q        <= '0;
			dir_z_q        <= '0;
			phase_offset_q <= '0;
			sea_level_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				swe_pkg::REG_WAVE_HEIGHT:  wave_height_q  <= pwdata[23:0];
				swe_pkg::REG_WAVE_NUMBER:  wave_number_q  <= pwdata[23:0];
				swe_pkg::REG_CELERITY:     celerity_q     <= pwdata[23:0];
				swe_pkg::REG_DIR_X:        dir_x_q        <= pwdata[15:0];
				swe_pkg::REG_DIR_Y:        dir_y_q        <= pwdata[15:0];
				swe_pkg::REG_DIR_Z:        dir_z_q        <= pwdata[15:0];
				swe_pkg::REG_PHASE_OFFSET: phase_offset_q <= pwdata;
				swe_pkg::REG_SEA_LEVEL:    sea_level_q    <= pwdata;
			endcase
		end
	end

	// Read-back: the signed direction components come back sign-extended.
	always_comb begin
		unique case (cfg_idx)
			swe_pkg::REG_WAVE_HEIGHT:  prdata = {8'd0, wave_height_q};
			swe_pkg::REG_WAVE_NUMBER:  prdata = {8'd0, wave_number_q};
			swe_pkg::REG_CELERITY:     prdata = {8'd0, celerity_q};
			swe_pkg::REG_DIR_X:        prdata = {{16{dir_x_q[15]}}, dir_x_q};
			swe_pkg::REG_DIR_Y:        prdata = {{16{dir_y_q[15]}}, dir_y_q};
			swe_pkg::REG_DIR_Z:        prdata = {{16{dir_z_q[15]}}, dir_z_q};
			swe_pkg::REG_PHASE_OFFSET: prdata = phase_offset_q;
			swe_pkg::REG_SEA_LEVEL:    prdata = sea_level_q;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline advance. The whole pipeline moves together while the skid
	// buffer is empty; a full skid buffer holds every stage in place.
	// ------------------------------------------------------------------
	logic skid_valid_q;
	logic en;

	assign en          = !skid_valid_q;
	assign query_stall = skid_valid_q;

	// ------------------------------------------------------------------
	// Front stages: phase, its magnitude, theta and the ln 2 range reduction.
	// ------------------------------------------------------------------
	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic signed [47:0]  px_s1, py_s1, pz_s1;
	logic [55:0]         ct_s1;
	logic [49:0]         proj_s2;
	logic [57:0]         cp_s2;
	logic [58:0]         u_s3;
	logic [57:0]         mag_s4;
	logic [57:0]         hi_s5;
	logic [23:0]         lo_s5;
	logic [35:0]         theta_s6;
	logic                flush_s6;
	logic [36:0]         y_s7;
	logic [5:0]          qe_s7;
	logic                flush_s7;
	logic [32:0]         r_s8;
	logic [5:0]          n_s8;
	logic                flush_s8;
	logic [31:0]         s_s9;
	logic [6:0]          sh_s9;

	logic [58:0]         u_neg;
	logic [47:0]         lo_full;
	logic [57:0]         theta_sum;
	logic [36:0]         y_dbl;
	logic [37:0]         qe_prod;
	logic [37:0]         qm;
	logic [37:0]         r_full;
	logic                r_ge;
	logic [32:0]         s_hi;
	logic [31:0]         s_lo;
	logic [6:0]          n_plus;

	always_comb begin
		u_neg     = ~u_s3 + 59'd1;
		lo_full   = mag_s4[23:0] * wave_number_q;
		theta_sum = hi_s5 + {34'd0, lo_s5};
		y_dbl     = {theta_s6, 1'b0};
		qe_prod   = y_dbl[36:20] * swe_pkg::RECIP_LN2;
		qm        = qe_s7 * swe_pkg::LN2_Q32;
		r_full    = {1'b0, y_s7} - qm;
		// The estimate is at most one short, so one correction step finishes it.
		r_ge      = (r_s8 >= {1'b0, swe_pkg::LN2_Q32});
		s_hi      = {swe_pkg::LN2_Q32, 1'b0} - r_s8;
		s_lo      = swe_pkg::LN2_Q32 - r_s8[31:0];
		n_plus    = {1'b0, n_s8} + (r_ge ? 7'd2 : 7'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= query_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Products of the point with the direction (Q.30) and of celerity with time.
			px_s1    <= pos_x * dir_x_q;
			py_s1    <= pos_y * dir_y_q;
			pz_s1    <= pos_z * dir_z_q;
			ct_s1    <= celerity_q * sim_time;

			proj_s2  <= {{2{px_s1[47]}}, px_s1} + {{2{py_s1[47]}}, py_s1}
			          + {{2{pz_s1[47]}}, pz_s1};
			cp_s2    <= {2'b00, ct_s1} + {{10{phase_offset_q[31]}}, phase_offset_q, 16'd0};

			// The phase in Q.32: the projection is scaled from Q.30 by four.
			u_s3     <= {cp_s2[57], cp_s2} - {{7{proj_s2[49]}}, proj_s2, 2'b00};

			mag_s4   <= u_s3[58] ? u_neg[57:0] : u_s3[57:0];

			hi_s5    <= mag_s4[57:24] * wave_number_q;
			lo_s5    <= lo_full[47:24];

			// Arguments of 16.0 and above flush the wave term to zero.
			theta_s6 <= theta_sum[35:0];
			flush_s6 <= |theta_sum[57:36];

			y_s7     <= y_dbl;
			qe_s7    <= qe_prod[37:32];
			flush_s7 <= flush_s6;

			r_s8     <= r_full[32:0];
			n_s8     <= qe_s7;
			flush_s8 <= flush_s7;

			s_s9     <= r_ge ? s_hi[31:0] : s_lo;
			// A flushed beat gets a shift that clears the exponential, so the
			// rest of the pipeline yields a zero wave term for it.
			sh_s9    <= flush_s8 ? 7'd127 : n_plus;
		end
	end

	// ------------------------------------------------------------------
	// exp(-y) before the final shift, one table entry per stage.
	// ------------------------------------------------------------------
	logic        exp_vld;
	logic [33:0] exp_p;
	logic [6:0]  exp_sh;

	swe_exp_pipe #(
		.STAGES (CORDIC_STAGES)
	) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s9),
		.in_s      (s_s9),
		.in_sh     (sh_s9),
		.out_valid (exp_vld),
		.out_p     (exp_p),
		.out_sh    (exp_sh)
	);

	// w = p >> (n + 1), never above 1.0.
	logic        vld_s10;
	logic [32:0] w_s10;
	logic [33:0] p_shr;

	assign p_shr = exp_p >> exp_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= exp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s10 <= (p_shr > 34'h1_0000_0000) ? 33'h1_0000_0000 : p_shr[32:0];
		end
	end

	// ------------------------------------------------------------------
	// a = w / (1 + w) in Q.31.
	// ------------------------------------------------------------------
	logic        div_vld;
	logic [30:0] div_a;

	swe_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s10),
		.in_w      (w_s10),
		.out_valid (div_vld),
		.out_a     (div_a)
	);

	// ------------------------------------------------------------------
	// sech^2 = 4a(1 - a), then the height scaling and the sea level.
	// ------------------------------------------------------------------
	logic        vld_s11, vld_s12, vld_s13;
	logic [30:0] a_s11;
	logic [31:0] b_s11;
	logic [62:0] prod_s12;
	logic [56:0] hp_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s11 <= div_vld;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s11    <= div_a;
			b_s11    <= 32'h8000_0000 - {1'b0, div_a};
			prod_s12 <= a_s11 * b_s11;
			// prod >> 28 is sech^2 in Q.32 and never exceeds 33 bits.
			hp_s13   <= wave_height_q * prod_s12[60:28];
		end
	end

	// The wave term is never negative, so only the upper bound can be crossed.
	logic [32:0] elev_sum;
	logic        elev_ovf;
	logic [31:0] elev_next;

	always_comb begin
		elev_sum  = {sea_level_q[31], sea_level_q} + {8'd0, hp_s13[56:32]};
		elev_ovf  = !sea_level_q[31] && elev_sum[31];
		elev_next = elev_ovf ? 32'h7FFF_FFFF : elev_sum[31:0];
	end

	// ------------------------------------------------------------------
	// Output register and skid buffer.
	// ------------------------------------------------------------------
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [31:0] skid_data_q;
	logic        out_take;

	assign out_take = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= vld_s13;
		end else if (vld_s13) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || out_take) begin
			out_data_q <= elev_next;
		end else begin
			skid_data_q <= elev_next;
		end
	end

	assign result_valid = out_valid_q;
	assign elevation    = out_data_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid buffer holds a beat while the output register is empty");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_stall && !skid_valid_q && vld_s13) |=> skid_valid_q)
		else $error("a finished beat was not parked while the output was stalled");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(result_stall) && $past(out_valid_q))
		else $error("skid buffer filled without a stalled output");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !result_stall) |=> !skid_valid_q && out_valid_q)
		else $error("skid buffer did not drain when the output was taken");

endmodule

/* hw/rtl/swe_exp_pipe.sv */
module swe_exp_pipe #(
	parameter int STAGES = swe_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] in_s,
	input  logic [6:0]  in_sh,
	output logic        out_valid,
	output logic [33:0] out_p,
	output logic [6:0]  out_sh
);

	// Shift-and-add exponential: one table entry tried per stage.
	logic                  vld_s [STAGES];
	swe_pkg::exp_beat_t    stg_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		localparam int I = g + 1;
		swe_pkg::exp_beat_t prev;
		swe_pkg::exp_beat_t nxt;
		logic               prev_vld;

		if (g == 0) begin : g_first
			assign prev.s    = in_s;
			assign prev.p    = 34'h1_0000_0000;
			assign prev.sh   = in_sh;
			assign prev_vld  = in_valid;
		end else begin : g_rest
			assign prev      = stg_s[g-1];
			assign prev_vld  = vld_s[g-1];
		end

		always_comb begin
			nxt = prev;
			if (prev.s >= swe_pkg::LN_ROM[I]) begin
				nxt.s = prev.s - swe_pkg::LN_ROM[I];
				nxt.p = prev.p + (prev.p >> I);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[g] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_p     = stg_s[STAGES-1].p;
	assign out_sh    = stg_s[STAGES-1].sh;

endmodule

/* hw/rtl/swe_div_pipe.sv */
module swe_div_pipe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [32:0] in_w,
	output logic        out_valid,
	output logic [30:0] out_a
);

	// Restoring divider for a = floor(w * 2^31 / (2^32 + w)), one quotient bit per stage.
	// The quotient never reaches 2^31, so the remainder starts out as w itself.
	localparam int N = swe_pkg::DIV_STEPS;

	logic                  vld_s [N];
	swe_pkg::div_beat_t    stg_s [N];

	for (genvar g = 0; g < N; g++) begin : g_step
		swe_pkg::div_beat_t prev;
		swe_pkg::div_beat_t nxt;
		logic               prev_vld;
		logic [34:0]        rr;
		logic               ge;

		if (g == 0) begin : g_first
			assign prev.r   = {1'b0, in_w};
			assign prev.d   = 34'h1_0000_0000 + {1'b0, in_w};
			assign prev.q   = '0;
			assign prev_vld = in_valid;
		end else begin : g_rest
			assign prev     = stg_s[g-1];
			assign prev_vld = vld_s[g-1];
		end

		always_comb begin
			rr    = {prev.r, 1'b0};
			ge    = (rr >= {1'b0, prev.d});
			nxt   = prev;
			nxt.q = {prev.q[29:0], ge};
			if (ge) begin
				nxt.r = 34'(rr - {1'b0, prev.d});
			end else begin
				nxt.r = rr[33:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[g] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_a     = stg_s[N-1].q;

endmodule
